// ===== sv/assert_macros.svh =====
// Assertion macros shared by the buffer cache tag engine.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define BBC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bbc_pkg.sv =====
// Package for the buffer cache tag engine: opcodes, status codes,
// sequencer states and the stored entry and result records. No dependencies.
package bbc_pkg;

    typedef enum logic [2:0] {
        OP_GET     = 3'd0,
        OP_READ    = 3'd1,
        OP_RELEASE = 3'd2,
        OP_MARK    = 3'd3,
        OP_WRITE   = 3'd4
    } bbc_op_t;

    typedef enum logic [2:0] {
        ST_HIT    = 3'd0,
        ST_ALLOC  = 3'd1,
        ST_NOFREE = 3'd2,
        ST_FREED  = 3'd3,
        ST_DONE   = 3'd4
    } bbc_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_SCAN,
        S_SHIFT,
        S_HREAD,
        S_MODIFY,
        S_DONE
    } bbc_state_t;

    typedef struct packed {
        logic [15:0] dev;
        logic [31:0] blk;
        logic [7:0]  cnt;
        logic        stale;
    } bbc_entry_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  entry;
        logic        do_read;
        logic        do_write;
        logic [15:0] io_device;
        logic [31:0] io_block;
    } bbc_result_t;

    localparam bbc_entry_t ENTRY_INIT = '{dev: 16'd0, blk: 32'd0, cnt: 8'd0, stale: 1'b1};

endpackage

// ===== sv/bbc_if.sv =====
// Request and response channel interfaces of the buffer cache tag engine.
// Valid/ready handshake; no dependencies.
interface bbc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] device;
    logic [31:0] block_number;
    logic [2:0]  size_class;
    logic [3:0]  handle;

    modport source (output valid, opcode, device, block_number, size_class, handle,
                    input ready);
    modport sink   (input valid, opcode, device, block_number, size_class, handle,
                    output ready);
endinterface

interface bbc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  entry;
    logic        do_read;
    logic        do_write;
    logic [15:0] io_device;
    logic [31:0] io_block;

    modport source (output valid, status, entry, do_read, do_write, io_device, io_block,
                    input ready);
    modport sink   (input valid, status, entry, do_read, do_write, io_device, io_block,
                    output ready);
endinterface

// ===== sv/bbc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/block_buffer_cache_tags.sv =====
// Buffer cache tag engine. One transaction in gives one transaction out. After reset a
// clearing pass over all SIZE_CLASSES*ENTRIES_PER_CLASS entries (112 by default) initializes
// the tag and order memories; no request is taken meanwhile. A release, mark or write reads
// and rewrites its entry, and a rejected request goes straight to the result; a get or read
// with a nonzero device walks the class's entries through the registered-read tag memory,
// and on a miss walks the replacement order through both memories and then rewrites the
// order tail one word a cycle.
// A finished result sits in an output register and waits there for the sink.
// Depends on bbc_pkg, bbc_if, bbc_ram and assert_macros.svh.
`include "assert_macros.svh"

module block_buffer_cache_tags #(
    parameter int SIZE_CLASSES      = 7,
    parameter int ENTRIES_PER_CLASS = 16
) (
    input logic clk,
    input logic rst_n,
    bbc_req_if.sink   req,
    bbc_rsp_if.source rsp
);
    import bbc_pkg::*;

    localparam int TOTAL = SIZE_CLASSES * ENTRIES_PER_CLASS;
    localparam int AW    = $clog2(TOTAL);
    localparam int EW    = $clog2(ENTRIES_PER_CLASS);
    localparam int CNTW  = EW + 1;
    localparam logic [CNTW-1:0] E_CNT  = CNTW'(ENTRIES_PER_CLASS);
    localparam logic [EW-1:0]   E_LAST = EW'(ENTRIES_PER_CLASS - 1);
    localparam logic [AW-1:0]   A_LAST = AW'(TOTAL - 1);

    bbc_state_t state_reg, state_next;

    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [EW-1:0]   clr_pos_reg, clr_pos_next;
    logic            out_valid_reg, out_valid_next;

    logic [2:0]      op_reg, op_next;
    logic [15:0]     dev_reg, dev_next;
    logic [31:0]     blk_reg, blk_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [EW-1:0]   e_reg, e_next;
    logic            hit_reg, hit_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            v1_reg, v1_next;
    logic [EW-1:0]   i1_reg, i1_next;
    logic            v2_reg, v2_next;
    logic [EW-1:0]   i2_reg, i2_next;
    logic [EW-1:0]   e2_reg, e2_next;
    bbc_result_t     res_reg, res_next;
    bbc_result_t     out_reg, out_next;

    logic            ent_we, ord_we;
    logic [AW-1:0]   ent_waddr, ent_raddr, ord_waddr, ord_raddr;
    bbc_entry_t      ent_wdata, ent_rdata;
    logic [EW-1:0]   ord_wdata, ord_rdata;

    logic            accept, reject_in, is_get, match, scan_found, out_free;
    bbc_entry_t      mod_entry;
    bbc_result_t     mod_res, reject_res;

    // Tag, count and stale memory; replacement order memory
    bbc_ram #(.WIDTH($bits(bbc_entry_t)), .DEPTH(TOTAL)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    bbc_ram #(.WIDTH(EW), .DEPTH(TOTAL)) u_ord_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    // Decode the request and the walk conditions
    always_comb
    begin
        accept     = req.valid && req.ready;
        reject_in  = (32'(req.size_class) >= SIZE_CLASSES)
                  || (req.opcode > OP_WRITE)
                  || ((req.opcode == OP_RELEASE || req.opcode == OP_MARK
                       || req.opcode == OP_WRITE)
                      && (32'(req.handle) >= ENTRIES_PER_CLASS));
        is_get     = (op_reg == OP_GET) || (op_reg == OP_READ);
        match      = v1_reg && (ent_rdata.dev == dev_reg) && (ent_rdata.blk == blk_reg);
        scan_found = v2_reg && (ent_rdata.cnt == 8'd0);
        out_free   = !out_valid_reg || rsp.ready;
        reject_res = '0;
        reject_res.status = ST_NOFREE;
    end

    // Build the updated entry and the result
    always_comb
    begin
        mod_entry = ent_rdata;
        mod_res   = '0;
        mod_res.entry = 4'(e_reg);
        if (is_get && !hit_reg)
        begin
            mod_entry.dev   = dev_reg;
            mod_entry.blk   = blk_reg;
            mod_entry.cnt   = 8'd1;
            mod_entry.stale = (op_reg != OP_READ);
            mod_res.status  = ST_ALLOC;
            mod_res.do_read = (op_reg == OP_READ);
        end
        else if (is_get)
        begin
            if (ent_rdata.cnt != 8'hFF)
            begin
                mod_entry.cnt = ent_rdata.cnt + 8'd1;
            end
            mod_entry.stale  = 1'b0;
            mod_res.status   = ST_HIT;
            mod_res.do_write = ent_rdata.stale;
        end
        else
        begin
            mod_res.status = ST_DONE;
            if (op_reg == OP_MARK || op_reg == OP_WRITE)
            begin
                mod_entry.stale = 1'b1;
            end
            if (op_reg == OP_RELEASE || op_reg == OP_WRITE)
            begin
                if (ent_rdata.cnt == 8'd0)
                begin
                    mod_res.status = ST_FREED;
                end
                else
                begin
                    mod_entry.cnt = ent_rdata.cnt - 8'd1;
                end
                mod_res.do_write = mod_entry.stale;
                mod_entry.stale  = 1'b0;
            end
        end
        mod_res.io_device = mod_entry.dev;
        mod_res.io_block  = mod_entry.blk;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (clr_addr_reg == A_LAST) state_next = S_IDLE;
            S_IDLE:
                if (accept)
                begin
                    if (reject_in)
                        state_next = S_DONE;
                    else if (req.opcode == OP_GET || req.opcode == OP_READ)
                        state_next = (req.device == 16'd0) ? S_SCAN : S_SEARCH;
                    else
                        state_next = S_HREAD;
                end
            S_SEARCH:
                if (match)
                    state_next = S_HREAD;
                else if (v1_reg && i1_reg == E_LAST)
                    state_next = S_SCAN;
            S_SCAN:
                if (scan_found)
                    state_next = S_SHIFT;
                else if (v2_reg && i2_reg == E_LAST)
                    state_next = S_DONE;
            S_SHIFT:
                if (!v1_reg && cnt_reg == E_CNT) state_next = S_MODIFY;
            S_HREAD:
                state_next = S_MODIFY;
            S_MODIFY:
                state_next = S_DONE;
            S_DONE:
                if (out_free) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Memory controls
    always_comb
    begin
        ent_we    = 1'b0;
        ent_waddr = base_reg + AW'(e_reg);
        ent_wdata = mod_entry;
        ent_raddr = base_reg + AW'(e_reg);
        ord_we    = 1'b0;
        ord_waddr = base_reg + AW'(E_LAST);
        ord_wdata = e_reg;
        ord_raddr = base_reg + AW'(cnt_reg[EW-1:0]);
        case (state_reg)
            S_CLEAR:
            begin
                ent_we    = 1'b1;
                ent_waddr = clr_addr_reg;
                ent_wdata = ENTRY_INIT;
                ord_we    = 1'b1;
                ord_waddr = clr_addr_reg;
                ord_wdata = clr_pos_reg;
            end
            S_SEARCH:
                ent_raddr = base_reg + AW'(cnt_reg[EW-1:0]);
            S_SCAN:
                ent_raddr = base_reg + AW'(ord_rdata);
            S_SHIFT:
                if (v1_reg)
                begin
                    ord_we    = 1'b1;
                    ord_waddr = base_reg + AW'(i1_reg - EW'(1));
                    ord_wdata = ord_rdata;
                end
                else if (cnt_reg == E_CNT)
                begin
                    ord_we = 1'b1;
                end
            S_MODIFY:
                ent_we = 1'b1;
            default:
            begin
                ent_we = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        clr_pos_next   = clr_pos_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        op_next   = op_reg;
        dev_next  = dev_reg;
        blk_next  = blk_reg;
        base_next = base_reg;
        e_next    = e_reg;
        hit_next  = hit_reg;
        cnt_next  = cnt_reg;
        v1_next   = v1_reg;
        i1_next   = i1_reg;
        v2_next   = v2_reg;
        i2_next   = i2_reg;
        e2_next   = e2_reg;
        res_next  = res_reg;
        out_next  = out_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                clr_pos_next  = (clr_pos_reg == E_LAST) ? '0 : clr_pos_reg + EW'(1);
            end
            S_IDLE:
                if (accept)
                begin
                    op_next   = req.opcode;
                    dev_next  = req.device;
                    blk_next  = req.block_number;
                    base_next = AW'(32'(req.size_class) * ENTRIES_PER_CLASS);
                    e_next    = EW'(req.handle);
                    hit_next  = 1'b0;
                    cnt_next  = '0;
                    v1_next   = 1'b0;
                    v2_next   = 1'b0;
                    res_next  = reject_res;
                end
            S_SEARCH:
            begin
                // Issue the next tag read, check the one read last cycle
                v1_next = (cnt_reg < E_CNT);
                i1_next = cnt_reg[EW-1:0];
                if (cnt_reg < E_CNT) cnt_next = cnt_reg + CNTW'(1);
                if (match)
                begin
                    e_next   = i1_reg;
                    hit_next = 1'b1;
                end
                else if (v1_reg && i1_reg == E_LAST)
                begin
                    cnt_next = '0;
                    v1_next  = 1'b0;
                    v2_next  = 1'b0;
                end
            end
            S_SCAN:
            begin
                // Order read, then count read of that entry, then test
                v1_next = (cnt_reg < E_CNT);
                i1_next = cnt_reg[EW-1:0];
                if (cnt_reg < E_CNT) cnt_next = cnt_reg + CNTW'(1);
                v2_next = v1_reg;
                i2_next = i1_reg;
                e2_next = ord_rdata;
                if (scan_found)
                begin
                    e_next   = e2_reg;
                    cnt_next = CNTW'(i2_reg) + CNTW'(1);
                    v1_next  = 1'b0;
                end
            end
            S_SHIFT:
            begin
                // Move each later order word down by one place
                v1_next = (cnt_reg < E_CNT);
                i1_next = cnt_reg[EW-1:0];
                if (cnt_reg < E_CNT) cnt_next = cnt_reg + CNTW'(1);
            end
            S_MODIFY:
                res_next = mod_res;
            S_DONE:
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            clr_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_pos_reg   <= clr_pos_next;
            out_valid_reg <= out_valid_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        dev_reg  <= dev_next;
        blk_reg  <= blk_next;
        base_reg <= base_next;
        e_reg    <= e_next;
        hit_reg  <= hit_next;
        cnt_reg  <= cnt_next;
        i1_reg   <= i1_next;
        i2_reg   <= i2_next;
        e2_reg   <= e2_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // Ports
    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_reg.status;
    assign rsp.entry     = out_reg.entry;
    assign rsp.do_read   = out_reg.do_read;
    assign rsp.do_write  = out_reg.do_write;
    assign rsp.io_device = out_reg.io_device;
    assign rsp.io_block  = out_reg.io_block;

    `BBC_ASSERT_SAME(a_clear_quiet, state_reg == S_CLEAR, !out_valid_reg, "result during clear")
    `BBC_ASSERT_SAME(a_search_ro, state_reg == S_SEARCH, !ent_we && !ord_we, "write during search")
    `BBC_ASSERT_NEXT(a_accept_busy, accept, state_reg != S_IDLE, "idle right after accept")

endmodule

// ===== test/tb_block_buffer_cache_tags.sv =====
// Testbench for the buffer cache tag engine: directed table, then random transactions
// checked against a behavioral predictor of tags, counts, stale flags and order.
// Depends on bbc_pkg, bbc_if and block_buffer_cache_tags.
`timescale 1ns / 100ps

module tb_block_buffer_cache_tags;
    import bbc_pkg::*;

    localparam int NCLS = 7;
    localparam int NENT = 16;
    localparam int NTOT = NCLS * NENT;
    localparam int NRAND = 1458;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] dev;
        logic [31:0] blk;
        logic [2:0]  cls;
        logic [3:0]  hdl;
    } req_t;

    // one directed row: request, and optionally a typed-in expected result
    typedef struct packed {
        req_t        rq;
        logic        fixed;
        bbc_result_t res;
    } row_t;

    logic clk;
    logic rst_n;
    bbc_req_if req ();
    bbc_rsp_if rsp ();

    block_buffer_cache_tags u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // cache image held by the testbench
    logic [15:0] tag_dev [NTOT];
    logic [31:0] tag_blk [NTOT];
    logic [7:0]  refs    [NTOT];
    logic        dirty   [NTOT];
    logic [3:0]  order   [NTOT];

    bbc_result_t pending_results[$];
    int          errors;
    logic [15:0] recent_dev[8];
    logic [31:0] recent_blk[8];

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic bbc_result_t rejected();
        bbc_result_t r;
        r = '0;
        r.status = ST_NOFREE;
        return r;
    endfunction

    // compute the result of one request and update the cache image
    function automatic bbc_result_t cache_lookup(req_t q);
        bbc_result_t r;
        int base;
        int e;
        int p;
        bit hit;
        bit freed;
        r = '0;
        if (q.cls >= NCLS || q.op > OP_WRITE)
            return rejected();
        base = q.cls * NENT;
        e = 0;
        hit = 0;
        if (q.op == OP_GET || q.op == OP_READ) begin
            if (q.dev != 0)
                for (int i = 0; i < NENT && !hit; i++)
                    if (tag_dev[base + i] == q.dev && tag_blk[base + i] == q.blk) begin
                        e = i;
                        hit = 1;
                    end
            if (hit) begin
                if (refs[base + e] != 8'd255)
                    refs[base + e]++;
                if (dirty[base + e]) begin
                    r.do_write = 1'b1;
                    dirty[base + e] = 1'b0;
                end
                r.status = ST_HIT;
            end else begin
                freed = 0;
                p = 0;
                for (int i = 0; i < NENT && !freed; i++)
                    if (refs[base + order[base + i]] == 0) begin
                        p = i;
                        freed = 1;
                    end
                if (!freed)
                    return rejected();
                e = order[base + p];
                for (int i = p; i < NENT - 1; i++)
                    order[base + i] = order[base + i + 1];
                order[base + NENT - 1] = 4'(e);
                tag_dev[base + e] = q.dev;
                tag_blk[base + e] = q.blk;
                refs[base + e] = 8'd1;
                dirty[base + e] = 1'b1;
                r.status = ST_ALLOC;
            end
            if (q.op == OP_READ && dirty[base + e]) begin
                r.do_read = 1'b1;
                dirty[base + e] = 1'b0;
            end
        end else begin
            e = q.hdl;
            if (q.op != OP_RELEASE)
                dirty[base + e] = 1'b1;
            r.status = ST_DONE;
            if (q.op != OP_MARK) begin
                if (refs[base + e] == 0)
                    r.status = ST_FREED;
                else
                    refs[base + e]--;
                if (dirty[base + e]) begin
                    r.do_write = 1'b1;
                    dirty[base + e] = 1'b0;
                end
            end
        end
        r.entry = 4'(e);
        r.io_device = tag_dev[base + e];
        r.io_block = tag_blk[base + e];
        return r;
    endfunction

    function automatic req_t mk(int op, int dev, longint blk, int cls, int hdl);
        req_t q;
        q.op = 3'(op);
        q.dev = 16'(dev);
        q.blk = 32'(blk);
        q.cls = 3'(cls);
        q.hdl = 4'(hdl);
        return q;
    endfunction

    // drive one transaction after a random gap; called and returns at a falling edge
    task automatic send(req_t q, logic fixed, bbc_result_t want);
        bbc_result_t got;
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        got = cache_lookup(q);
        if (fixed && got !== want) begin
            $display("%0t: table row disagrees with predictor, expected %h actual %h",
                     $time, want, got);
            errors++;
        end
        pending_results.push_back(fixed ? want : got);
        req.valid <= 1'b1;
        req.opcode <= q.op;
        req.device <= q.dev;
        req.block_number <= q.blk;
        req.size_class <= q.cls;
        req.handle <= q.hdl;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random request: mostly well-formed traffic on a small tag set
    function automatic req_t random_request();
        req_t q;
        int k;
        q.op = ($urandom_range(0, 40) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
        q.cls = ($urandom_range(0, 40) == 0) ? 3'd7 : 3'($urandom_range(0, 2));
        if ($urandom_range(0, 9) == 0)
            q.cls = 3'($urandom_range(3, 6));
        k = $urandom_range(0, 7);
        q.dev = recent_dev[k];
        q.blk = recent_blk[k];
        if ($urandom_range(0, 15) == 0) begin
            q.dev = 16'($urandom);
            q.blk = $urandom;
        end
        q.hdl = 4'($urandom);
        // releases and writes often target recently allocated entries so counts do not just pile up
        if (q.op == OP_RELEASE || q.op == OP_WRITE)
            if ($urandom_range(0, 1) == 0)
                q.hdl = order[q.cls * NENT + NENT - 1 - $urandom_range(0, 3)];
        return q;
    endfunction

    // response side: random stall per transaction, compare with the oldest expectation
    initial
    begin
        bbc_result_t want;
        int stall;
        rsp.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, 4);
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d", $time, rsp.status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status || rsp.entry !== want.entry
                    || rsp.do_read !== want.do_read || rsp.do_write !== want.do_write
                    || rsp.io_device !== want.io_device
                    || rsp.io_block !== want.io_block) begin
                    $display("%0t: mismatch expected %0d/%0d/%0d/%0d/%h/%h actual %0d/%0d/%0d/%0d/%h/%h",
                             $time, want.status, want.entry, want.do_read, want.do_write,
                             want.io_device, want.io_block, rsp.status, rsp.entry,
                             rsp.do_read, rsp.do_write, rsp.io_device, rsp.io_block);
                    errors++;
                end
            end
            @(negedge clk);
        end
    end

    // stimulus
    initial
    begin
        row_t table_rows[$];
        row_t rw;
        bbc_result_t none;
        errors = 0;
        none = '0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.opcode = '0;
        req.device = '0;
        req.block_number = '0;
        req.size_class = '0;
        req.handle = '0;
        for (int i = 0; i < NTOT; i++) begin
            tag_dev[i] = '0;
            tag_blk[i] = '0;
            refs[i] = '0;
            dirty[i] = 1'b1;
            order[i] = 4'(i % NENT);
        end
        for (int i = 0; i < 8; i++) begin
            recent_dev[i] = (i == 0) ? 16'd0 : 16'($urandom);
            recent_blk[i] = (i < 2) ? 32'hFFFF_FFFF : $urandom;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: typed results after reset, rejections, extremes
        table_rows.push_back('{mk(OP_RELEASE, 0, 0, 0, 0), 1'b1,
                               '{ST_FREED, 4'd0, 1'b0, 1'b1, 16'd0, 32'd0}});
        table_rows.push_back('{mk(OP_GET, 0, 0, 0, 0), 1'b1,
                               '{ST_ALLOC, 4'd0, 1'b0, 1'b0, 16'd0, 32'd0}});
        table_rows.push_back('{mk(OP_READ, 16'hFFFF, 32'hFFFF_FFFF, 6, 0), 1'b1,
                               '{ST_ALLOC, 4'd0, 1'b1, 1'b0, 16'hFFFF, 32'hFFFF_FFFF}});
        table_rows.push_back('{mk(OP_GET, 16'hFFFF, 32'hFFFF_FFFF, 6, 0), 1'b1,
                               '{ST_HIT, 4'd0, 1'b0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF}});
        table_rows.push_back('{mk(OP_GET, 1, 2, 7, 0), 1'b1, rejected()});
        table_rows.push_back('{mk(5, 1, 2, 0, 0), 1'b1, rejected()});
        table_rows.push_back('{mk(7, 1, 2, 0, 0), 1'b1, rejected()});
        table_rows.push_back('{mk(OP_MARK, 0, 0, 6, 15), 1'b1,
                               '{ST_DONE, 4'd15, 1'b0, 1'b0, 16'd0, 32'd0}});
        table_rows.push_back('{mk(OP_WRITE, 0, 0, 6, 0), 1'b0, none});
        table_rows.push_back('{mk(OP_WRITE, 0, 0, 6, 0), 1'b0, none});
        table_rows.push_back('{mk(OP_MARK, 0, 0, 6, 0), 1'b0, none});
        table_rows.push_back('{mk(OP_GET, 0, 0, 6, 0), 1'b0, none});
        table_rows.push_back('{mk(OP_READ, 16'h1234, 32'h5678, 5, 9), 1'b0, none});
        table_rows.push_back('{mk(OP_READ, 16'h1234, 32'h5678, 5, 9), 1'b0, none});
        table_rows.push_back('{mk(OP_RELEASE, 0, 0, 5, 0), 1'b0, none});
        foreach (table_rows[i]) begin
            rw = table_rows[i];
            send(rw.rq, rw.fixed, rw.res);
        end

        // fill class 4 so a miss finds no free entry
        for (int i = 0; i < NENT + 1; i++)
            send(mk(OP_GET, 16'h4000, i, 4, 0), 1'b0, none);
        // drive one entry to count saturation
        for (int i = 0; i < 260; i++)
            send(mk(OP_GET, 16'h4000, 0, 4, 0), 1'b0, none);
        // drain every expected result before going random
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);

        for (int n = 0; n < NRAND; n++) begin
            if ($urandom_range(0, 19) == 0) begin
                recent_dev[$urandom_range(1, 7)] = 16'($urandom);
                recent_blk[$urandom_range(0, 7)] = $urandom;
            end
            send(random_request(), 1'b0, none);
        end

        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // timeout
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
